// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/adcbcd_pkg.sv =====
// Shared types and constants for the ADC code to BCD digit scan block.
`timescale 1ns / 1ps
`default_nettype none

package adcbcd_pkg;

  // Resolution select codes (value 3 behaves as 16-bit)
  localparam logic [1:0] RES_10B = 2'd0;
  localparam logic [1:0] RES_12B = 2'd1;
  localparam logic [1:0] RES_16B = 2'd2;

  // Configuration register indexes
  localparam logic CFG_IDX_RES  = 1'b0;
  localparam logic CFG_IDX_GAIN = 1'b1;

  localparam int CODE_W   = 16;
  localparam int GAIN_W   = 8;
  localparam int GAIN50_W = 14;
  localparam int PROD_W   = 30;
  localparam int TENTHS_W = 14;
  localparam int HALF_W   = 7;

  // Full-scale values
  localparam logic [15:0] FS_10B = 16'd1023;
  localparam logic [15:0] FS_12B = 16'd4095;
  localparam logic [15:0] FS_16B = 16'd65535;

  // Products at or above these saturate (10000 * full scale)
  localparam logic [PROD_W-1:0] SAT_LIM_10B = 30'd10230000;
  localparam logic [PROD_W-1:0] SAT_LIM_12B = 30'd40950000;
  localparam logic [PROD_W-1:0] SAT_LIM_16B = 30'd655350000;

  localparam logic [TENTHS_W-1:0] MAX_TENTHS = 14'd9999;

  // Reciprocals: x/100 = (x*5243)>>19 for x < 10000, x/10 = (x*205)>>11 for x < 100
  localparam logic [12:0] RCP100 = 13'd5243;
  localparam int          SH100  = 19;
  localparam logic [7:0]  RCP10  = 8'd205;
  localparam int          SH10   = 11;

  // Digit positions
  localparam logic [1:0] POS_TENTHS   = 2'd0;
  localparam logic [1:0] POS_UNITS    = 2'd1;
  localparam logic [1:0] POS_TENS     = 2'd2;
  localparam logic [1:0] POS_HUNDREDS = 2'd3;

  // Scaled value leaving the scale pipeline
  typedef struct packed {
    logic                vld;
    logic [TENTHS_W-1:0] val;
  } tenths_t;

  // Value split into hundreds part and remainder
  typedef struct packed {
    logic              vld;
    logic [HALF_W-1:0] hi;
    logic [HALF_W-1:0] lo;
  } split_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adcbcd_scale.sv =====
// Three-stage scaler: code * 50 * gain / full scale, saturated at 9999 tenths.
`timescale 1ns / 1ps
`default_nettype none

module adcbcd_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [adcbcd_pkg::CODE_W-1:0] code,
  input  logic [1:0]                    res_sel,
  input  logic [adcbcd_pkg::GAIN_W-1:0] gain,
  output adcbcd_pkg::tenths_t           tenths_o
);

  logic                              v1_r, v2_r, v3_r;
  logic [adcbcd_pkg::PROD_W-1:0]     p_r, p_nxt;
  logic                              sat_r, sat_nxt;
  logic [adcbcd_pkg::TENTHS_W-1:0]   q0_r, q0_nxt;
  logic [16:0]                       s_r, s_nxt;
  logic [adcbcd_pkg::TENTHS_W-1:0]   t_r, t_nxt;
  logic [adcbcd_pkg::GAIN50_W-1:0]   gain50;
  logic [15:0]                       r0;
  logic [adcbcd_pkg::PROD_W-1:0]     lim;
  logic [3:0]                        q1;
  logic [15:0]                       r1;
  logic [15:0]                       fs;
  logic [16:0]                       s2;
  logic                              corr;
  logic [adcbcd_pkg::TENTHS_W-1:0]   q;

  // Stage 1: gain * 50 by shift-add, then one multiply
  assign gain50 = {1'b0, gain, 5'b0} + {2'b0, gain, 4'b0} + {5'b0, gain, 1'b0};
  assign p_nxt  = {14'b0, code} * {16'b0, gain50};

  // Stage 2: first fold of the divide by 2^k-1, saturation compare
  always_comb begin
    case (res_sel)
      adcbcd_pkg::RES_10B: begin
        q0_nxt = p_r[23:10];
        r0     = {6'b0, p_r[9:0]};
        lim    = adcbcd_pkg::SAT_LIM_10B;
      end
      adcbcd_pkg::RES_12B: begin
        q0_nxt = p_r[25:12];
        r0     = {4'b0, p_r[11:0]};
        lim    = adcbcd_pkg::SAT_LIM_12B;
      end
      default: begin
        q0_nxt = p_r[29:16];
        r0     = p_r[15:0];
        lim    = adcbcd_pkg::SAT_LIM_16B;
      end
    endcase
    sat_nxt = (p_r >= lim);
    s_nxt   = {3'b0, q0_nxt} + {1'b0, r0};
  end

  // Stage 3: second fold, final correction, clamp
  always_comb begin
    case (res_sel)
      adcbcd_pkg::RES_10B: begin
        q1 = 4'(s_r[16:10]);
        r1 = {6'b0, s_r[9:0]};
        fs = adcbcd_pkg::FS_10B;
      end
      adcbcd_pkg::RES_12B: begin
        q1 = 4'(s_r[16:12]);
        r1 = {4'b0, s_r[11:0]};
        fs = adcbcd_pkg::FS_12B;
      end
      default: begin
        q1 = {3'b0, s_r[16]};
        r1 = s_r[15:0];
        fs = adcbcd_pkg::FS_16B;
      end
    endcase
    s2    = {13'b0, q1} + {1'b0, r1};
    corr  = (s2 >= {1'b0, fs});
    q     = q0_r + {10'b0, q1} + {13'b0, corr};
    t_nxt = sat_r ? adcbcd_pkg::MAX_TENTHS : q;
  end

  // Advance valid bits; hold everything while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      sat_r <= sat_nxt;
      q0_r  <= q0_nxt;
      s_r   <= s_nxt;
      t_r   <= t_nxt;
    end
  end

  assign tenths_o.vld = v3_r;
  assign tenths_o.val = t_r;

endmodule

`default_nettype wire

// ===== hw/rtl/adcbcd_split.sv =====
// Split stage: tenths value into value/100 and value%100.
`timescale 1ns / 1ps
`default_nettype none

module adcbcd_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  adcbcd_pkg::tenths_t tenths_i,
  output adcbcd_pkg::split_t  split_o
);

  logic                            vld_r;
  logic [adcbcd_pkg::HALF_W-1:0]   hi_r, hi_nxt;
  logic [adcbcd_pkg::HALF_W-1:0]   lo_r, lo_nxt;
  logic [26:0]                     hi_prod;
  logic [13:0]                     hi_x100;

  // Divide by 100 through the reciprocal, then take the remainder
  always_comb begin
    hi_prod = 27'(tenths_i.val) * 27'(adcbcd_pkg::RCP100);
    hi_nxt  = 7'(hi_prod >> adcbcd_pkg::SH100);
    hi_x100 = {7'b0, hi_nxt} * 14'd100;
    lo_nxt  = 7'(tenths_i.val - hi_x100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= tenths_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign split_o.vld = vld_r;
  assign split_o.hi  = hi_r;
  assign split_o.lo  = lo_r;

endmodule

`default_nettype wire

// ===== hw/rtl/adcbcd_scan.sv =====
// Digit serializer: forms four BCD digits and emits them most significant first, skipping leading zeros.
`timescale 1ns / 1ps
`default_nettype none

module adcbcd_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  adcbcd_pkg::split_t split_i,
  output logic               load_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_digit_position,
  output logic [3:0]         out_digit_value,
  output logic               out_point_pin_on,
  output logic               out_last_digit
);

  logic       vld_r, vld_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [3:0] d3_r, d2_r, d1_r, d0_r;
  logic [3:0] d3_nxt, d2_nxt, d1_nxt, d0_nxt;
  logic [14:0] hi_prod, lo_prod;
  logic [6:0]  hi_x10, lo_x10;
  logic [1:0]  first_pos;
  logic        out_take;

  // Split both halves into tens and units
  always_comb begin
    hi_prod = 15'(split_i.hi) * 15'(adcbcd_pkg::RCP10);
    lo_prod = 15'(split_i.lo) * 15'(adcbcd_pkg::RCP10);
    d3_nxt  = 4'(hi_prod >> adcbcd_pkg::SH10);
    d1_nxt  = 4'(lo_prod >> adcbcd_pkg::SH10);
    hi_x10  = {3'b0, d3_nxt} * 7'd10;
    lo_x10  = {3'b0, d1_nxt} * 7'd10;
    d2_nxt  = 4'(split_i.hi - hi_x10);
    d0_nxt  = 4'(split_i.lo - lo_x10);
  end

  // Drop leading zero positions above the units digit
  always_comb begin
    if (d3_nxt != 4'd0) begin
      first_pos = adcbcd_pkg::POS_HUNDREDS;
    end else if (d2_nxt != 4'd0) begin
      first_pos = adcbcd_pkg::POS_TENS;
    end else begin
      first_pos = adcbcd_pkg::POS_UNITS;
    end
  end

  assign out_take   = vld_r && !out_stall;
  assign load_ready = !vld_r || (out_take && (pos_r == adcbcd_pkg::POS_TENTHS));

  // Load a new item or step down one position per delivered digit
  always_comb begin
    vld_nxt = vld_r;
    pos_nxt = pos_r;
    if (load_ready) begin
      vld_nxt = split_i.vld;
      pos_nxt = first_pos;
    end else if (out_take) begin
      pos_nxt = pos_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      pos_r <= adcbcd_pkg::POS_UNITS;
    end else begin
      vld_r <= vld_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready) begin
      d3_r <= d3_nxt;
      d2_r <= d2_nxt;
      d1_r <= d1_nxt;
      d0_r <= d0_nxt;
    end
  end

  // Present the current digit
  always_comb begin
    case (pos_r)
      adcbcd_pkg::POS_HUNDREDS: out_digit_value = d3_r;
      adcbcd_pkg::POS_TENS:     out_digit_value = d2_r;
      adcbcd_pkg::POS_UNITS:    out_digit_value = d1_r;
      default:                  out_digit_value = d0_r;
    endcase
  end

  assign out_valid          = vld_r;
  assign out_digit_position = pos_r;
  assign out_point_pin_on   = (pos_r != adcbcd_pkg::POS_UNITS);
  assign out_last_digit     = (pos_r == adcbcd_pkg::POS_TENTHS);

endmodule

`default_nettype wire

// ===== hw/rtl/adc_code_to_bcd_digit_scan.sv =====
// Top level: ADC code scaled to tenths of a volt and scanned out as BCD digits.
// An accepted item passes the scaler stages and the split register before the serializer loads it.
// The digit serializer emits two to four digits per item and loads the next item as the last digit is taken.
// The pipeline holds up to five items; a stall at the output freezes all stages.
// Reset (synchronous, rst_n low) clears all valid bits; resolution select 0, gain 1.
`timescale 1ns / 1ps
`default_nettype none

module adc_code_to_bcd_digit_scan (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_idx,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_adc_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_digit_position,
  output logic [3:0]  out_digit_value,
  output logic        out_point_pin_on,
  output logic        out_last_digit
);

  logic [1:0]          res_sel_r;
  logic [7:0]          gain_r;
  logic                pipe_en;
  adcbcd_pkg::tenths_t tenths;
  adcbcd_pkg::split_t  split;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_sel_r <= adcbcd_pkg::RES_10B;
      gain_r    <= 8'd1;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        adcbcd_pkg::CFG_IDX_RES:  res_sel_r <= cfg_wdata[1:0];
        adcbcd_pkg::CFG_IDX_GAIN: gain_r    <= cfg_wdata;
        default:                  res_sel_r <= res_sel_r;
      endcase
    end
  end

  // Hold the whole pipeline while the serializer cannot take an item
  assign in_stall = !pipe_en;

  adcbcd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (in_valid),
    .code     (in_adc_code),
    .res_sel  (res_sel_r),
    .gain     (gain_r),
    .tenths_o (tenths)
  );

  adcbcd_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .tenths_i (tenths),
    .split_o  (split)
  );

  adcbcd_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .split_i            (split),
    .load_ready         (pipe_en),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_digit_value    (out_digit_value),
    .out_point_pin_on   (out_point_pin_on),
    .out_last_digit     (out_last_digit)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/adcbcd_chk.sv =====
// Port-level checker for the digit scan output, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module adcbcd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_digit_position,
  input logic [3:0] out_digit_value,
  input logic       out_point_pin_on,
  input logic       out_last_digit
);

  logic [7:0] out_bits;
  logic       flags_ok;
  logic       take_mid;
  logic [1:0] pos_dec_r;

  // Payload as one vector, expected flags, and a digit taken mid-run
  assign out_bits = {out_digit_position, out_digit_value, out_point_pin_on, out_last_digit};
  assign flags_ok = (out_point_pin_on == (out_digit_position != adcbcd_pkg::POS_UNITS)) &&
                    (out_last_digit == (out_digit_position == adcbcd_pkg::POS_TENTHS));
  assign take_mid = out_valid && !out_stall && !out_last_digit;

  // Track the position one below the current one
  always_ff @(posedge clk) begin
    pos_dec_r <= out_digit_position - 2'd1;
  end

  // A stalled item holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bits))

  // Digits stay BCD
  `ASSERT_IMPLY(a_bcd_range, clk, rst_n, out_valid, out_digit_value <= 4'd9)

  // Point pin and last flag follow the position
  `ASSERT_IMPLY(a_flags, clk, rst_n, out_valid, flags_ok)

  // A run steps down one position at a time until the tenths digit
  `ASSERT_NEXT(a_step_down, clk, rst_n, take_mid, out_valid && (out_digit_position == pos_dec_r))

endmodule

bind adc_code_to_bcd_digit_scan adcbcd_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_digit_position (out_digit_position),
  .out_digit_value    (out_digit_value),
  .out_point_pin_on   (out_point_pin_on),
  .out_last_digit     (out_last_digit)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the ADC code to BCD digit scan block.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEMS_PER_PH = 54;
  localparam int N_DIRECTED   = 20;

  // Spare resolution code, behaves as 16-bit
  localparam logic [1:0] RES_SPARE = 2'd3;

  // One displayed digit as it leaves the block
  typedef struct packed {
    logic [1:0] pos;
    logic [3:0] val;
    logic       point;
    logic       last;
  } digit_t;

  // Directed row: register setting, code, and the reading when it is obvious
  typedef struct packed {
    logic [1:0]                      res;
    logic [7:0]                      gain;
    logic [15:0]                     code;
    logic                            known;
    logic [adcbcd_pkg::TENTHS_W-1:0] tenths;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{adcbcd_pkg::RES_10B, 8'd1,   16'd0,     1'b1, 14'd0},     // reset setting, zero code
    '{adcbcd_pkg::RES_10B, 8'd1,   16'd1023,  1'b1, 14'd50},    // full scale reads 5.0
    '{adcbcd_pkg::RES_10B, 8'd1,   16'd65535, 1'b0, 14'd0},     // code above full scale
    '{adcbcd_pkg::RES_10B, 8'd255, 16'd1023,  1'b1, 14'd9999},  // overrange
    '{adcbcd_pkg::RES_10B, 8'd255, 16'd65535, 1'b1, 14'd9999},
    '{adcbcd_pkg::RES_10B, 8'd20,  16'd1023,  1'b1, 14'd1000},  // first four-digit reading
    '{adcbcd_pkg::RES_10B, 8'd20,  16'd1022,  1'b0, 14'd0},
    '{adcbcd_pkg::RES_10B, 8'd2,   16'd1023,  1'b1, 14'd100},   // first three-digit reading
    '{adcbcd_pkg::RES_10B, 8'd2,   16'd1022,  1'b0, 14'd0},
    '{adcbcd_pkg::RES_12B, 8'd1,   16'd4095,  1'b1, 14'd50},
    '{adcbcd_pkg::RES_12B, 8'd1,   16'd65535, 1'b0, 14'd0},
    '{adcbcd_pkg::RES_12B, 8'd0,   16'd4095,  1'b1, 14'd0},     // zero gain
    '{adcbcd_pkg::RES_12B, 8'd0,   16'd65535, 1'b1, 14'd0},
    '{adcbcd_pkg::RES_16B, 8'd255, 16'd65535, 1'b1, 14'd9999},
    '{adcbcd_pkg::RES_16B, 8'd200, 16'd65535, 1'b1, 14'd9999},  // exactly at the limit
    '{adcbcd_pkg::RES_16B, 8'd199, 16'd65535, 1'b1, 14'd9950},
    '{adcbcd_pkg::RES_16B, 8'd1,   16'd32768, 1'b0, 14'd0},
    '{RES_SPARE,           8'd1,   16'd65535, 1'b1, 14'd50},    // spare select acts as 16-bit
    '{RES_SPARE,           8'd128, 16'hAAAA,  1'b0, 14'd0},
    '{RES_SPARE,           8'd128, 16'h5555,  1'b0, 14'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_idx = adcbcd_pkg::CFG_IDX_RES;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_adc_code = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_digit_position;
  logic [3:0]  out_digit_value;
  logic        out_point_pin_on;
  logic        out_last_digit;

  digit_t digits_due [$];
  logic [1:0] cur_res = adcbcd_pkg::RES_10B;
  logic [7:0] cur_gain = 8'd1;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  adc_code_to_bcd_digit_scan i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_adc_code        (in_adc_code),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_digit_value    (out_digit_value),
    .out_point_pin_on   (out_point_pin_on),
    .out_last_digit     (out_last_digit)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scale a code to tenths of a volt, saturated at 999.9
  function automatic logic [adcbcd_pkg::TENTHS_W-1:0] scaled_tenths(input logic [15:0] code,
                                                                     input logic [1:0]  res,
                                                                     input logic [7:0]  gain);
    logic [31:0] prod;
    logic [31:0] fs;
    logic [31:0] t;
    case (res)
      adcbcd_pkg::RES_10B: fs = 32'(adcbcd_pkg::FS_10B);
      adcbcd_pkg::RES_12B: fs = 32'(adcbcd_pkg::FS_12B);
      default:             fs = 32'(adcbcd_pkg::FS_16B);
    endcase
    prod = 32'(code) * 32'd50 * 32'(gain);
    t = prod / fs;
    if (t > 32'(adcbcd_pkg::MAX_TENTHS)) t = 32'(adcbcd_pkg::MAX_TENTHS);
    return t[adcbcd_pkg::TENTHS_W-1:0];
  endfunction

  function automatic digit_t make_digit(input logic [1:0] pos, input int val);
    digit_t d;
    d.pos   = pos;
    d.val   = val[3:0];
    d.point = (pos != adcbcd_pkg::POS_UNITS);
    d.last  = (pos == adcbcd_pkg::POS_TENTHS);
    return d;
  endfunction

  // Queue the digits a reading shows, leading positions suppressed
  function automatic void queue_digits(input logic [adcbcd_pkg::TENTHS_W-1:0] tenths);
    int v;
    v = int'(tenths);
    if (v >= 1000) digits_due.push_back(make_digit(adcbcd_pkg::POS_HUNDREDS, v / 1000));
    if (v >= 100) digits_due.push_back(make_digit(adcbcd_pkg::POS_TENS, (v / 100) % 10));
    digits_due.push_back(make_digit(adcbcd_pkg::POS_UNITS, (v / 10) % 10));
    digits_due.push_back(make_digit(adcbcd_pkg::POS_TENTHS, v % 10));
  endfunction

  // Offer one code; return at the edge that takes it
  task automatic send_code(input logic [15:0] code, input logic known,
                           input logic [adcbcd_pkg::TENTHS_W-1:0] tenths);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_code <= code;
    do @(negedge clk); while (in_stall);
    queue_digits(known ? tenths : scaled_tenths(code, cur_res, cur_gain));
    @(posedge clk);
  endtask

  // Drain the block, then write both registers
  task automatic set_config(input logic [1:0] res, input logic [7:0] gain);
    in_valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= adcbcd_pkg::CFG_IDX_RES;
    cfg_wdata <= {6'd0, res};
    @(posedge clk);
    cfg_idx   <= adcbcd_pkg::CFG_IDX_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_res  = res;
    cur_gain = gain;
  endtask

  // Random codes with the setting changed every so often
  task automatic run_random(input int n_items);
    logic [15:0] fs;
    logic [15:0] code;
    logic [7:0] gain;
    for (int i = 0; i < n_items; i++) begin
      if (i % 15 == 0) begin
        case ($urandom_range(3))
          0: gain = 8'd0;
          1: gain = 8'd255;
          default: gain = 8'($urandom_range(255));
        endcase
        set_config(2'($urandom_range(3)), gain);
      end
      case (cur_res)
        adcbcd_pkg::RES_10B: fs = adcbcd_pkg::FS_10B;
        adcbcd_pkg::RES_12B: fs = adcbcd_pkg::FS_12B;
        default:             fs = adcbcd_pkg::FS_16B;
      endcase
      case ($urandom_range(3))
        0: code = 16'($urandom);
        1: code = 16'($urandom_range(int'(fs)));
        2: code = 16'($urandom_range(31));
        default: code = fs - 16'($urandom_range(3));
      endcase
      send_code(code, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each digit taken at the coming edge against the oldest one due
  always @(negedge clk) begin : check_digits
    digit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digits_due.size() == 0) begin
        $display("%0t: unexpected digit, expected none, actual pos %0d val %0d",
                 $time, out_digit_position, out_digit_value);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        if ({out_digit_position, out_digit_value, out_point_pin_on, out_last_digit}
            !== {want.pos, want.val, want.point, want.last}) begin
          $display("%0t: digit mismatch, expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
                   $time, want.pos, want.val, want.point, want.last,
                   out_digit_position, out_digit_value, out_point_pin_on, out_last_digit);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, sender idling lightly and receiver stalling hard
    send_idle_pct  = 8;
    recv_stall_pct = 84;
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].res != cur_res || DIRECTED[r].gain != cur_gain)
        set_config(DIRECTED[r].res, DIRECTED[r].gain);
      send_code(DIRECTED[r].code, DIRECTED[r].known, DIRECTED[r].tenths);
    end
    run_random(ITEMS_PER_PH);

    // Swap the pressure, then run at full rate
    send_idle_pct  = 84;
    recv_stall_pct = 8;
    run_random(ITEMS_PER_PH);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(ITEMS_PER_PH);

    in_valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
